// ===== src/ptlru_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types.
`timescale 1ns / 1ps
package ptlru_pkg;

  // Pool geometry
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = 6;
  localparam int IDX_W      = 7;
  localparam int ADDR_W     = 64;
  localparam int CNT_W      = 7;
  localparam logic [IDX_W-1:0] NO_SLOT = IDX_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] MAX_RESULTS = CNT_W'(SLOT_COUNT);

  // Page size, a power of two, so slot * size is a shift
  localparam longint PAGE_BYTES = 65536;
  localparam int     PAGE_SHIFT = $clog2(PAGE_BYTES);

  // Command codes
  typedef enum logic [2:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_TOUCH  = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_SELECT = 3'd4
  } cmd_t;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RESIDENT  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_SCAN_RD  = 4'd2,
    OP_SCAN_CMP = 4'd3,
    OP_POP_RD   = 4'd4,
    OP_POP_TAKE = 4'd5,
    OP_NEW_TAKE = 4'd6,
    OP_LINK1    = 4'd7,
    OP_LINK2    = 4'd8,
    OP_UNL_RD   = 4'd9,
    OP_UNL2     = 4'd10,
    OP_UNL3     = 4'd11,
    OP_SEL_INIT = 4'd12,
    OP_SEL_RD   = 4'd13,
    OP_EMIT     = 4'd14,
    OP_SEL_EMIT = 4'd15
  } dp_op_t;

  // Fields of a plain (non-select) result
  typedef struct packed {
    logic [1:0] status;
    logic       slot_ok;
    logic       resident;
  } res_t;

  typedef struct packed {
    dp_op_t op;
    res_t   res;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       out_busy;
    logic       match;
    logic       scan_last;
    logic       hit;
    logic       is_mr;
    logic       free_avail;
    logic       unused_avail;
    logic       sel_more;
    logic       sel_last;
  } dp_stat_t;

endpackage

// ===== src/ptlru_dp.sv =====
// Datapath: slot memories, recency links, free stack, counters and result register.
`timescale 1ns / 1ps
module ptlru_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ptlru_pkg::ctl_t   ctl,
  output ptlru_pkg::dp_stat_t stat,
  input  logic [2:0]        in_cmd,
  input  logic [63:0]       in_addr,
  input  logic [6:0]        in_max,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [6:0]        out_slot,
  output logic [63:0]       out_offset,
  output logic              out_resident,
  output logic [63:0]       out_victim,
  output logic              out_victim_valid,
  output logic              out_last
);
  import ptlru_pkg::*;

  // Storage
  logic [ADDR_W-1:0] addr_mem [SLOT_COUNT];
  logic [IDX_W-1:0]  prev_mem [SLOT_COUNT];
  logic [IDX_W-1:0]  next_mem [SLOT_COUNT];
  logic [SLOT_W-1:0] free_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;

  // Registered read data
  logic [ADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]  prev_q, next_q;
  logic [SLOT_W-1:0] free_q;

  // Working registers
  logic [2:0]        cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  lim_r, n_r;
  logic [SLOT_W-1:0] idx_r;
  logic [IDX_W-1:0]  s_r, cur_r;
  logic [CNT_W-1:0]  fc_r;
  logic [IDX_W-1:0]  nu_r, mr_r, lr_r;
  logic              out_valid_r;

  // Memory port controls
  logic              a_we, a_re, p_we, p_re, n_we, n_re, f_we, f_re;
  logic [SLOT_W-1:0] a_ra, p_wa, p_ra, n_wa, f_wa, f_ra;
  logic [IDX_W-1:0]  p_wd, n_wd;
  logic              match, sel_last;

  assign match    = valid_r[idx_r] && (addr_q == addr_r);
  assign sel_last = (prev_q >= NO_SLOT) || (CNT_W'(n_r + 7'd1) == lim_r);

  // Status toward the controller
  assign stat.cmd          = cmd_r;
  assign stat.out_busy     = out_valid_r;
  assign stat.match        = match;
  assign stat.scan_last    = (idx_r == SLOT_W'(SLOT_COUNT - 1));
  assign stat.hit          = (s_r < NO_SLOT);
  assign stat.is_mr        = (mr_r == s_r);
  assign stat.free_avail   = (fc_r != '0);
  assign stat.unused_avail = (nu_r < NO_SLOT);
  assign stat.sel_more     = (cur_r < NO_SLOT) && (n_r < lim_r);
  assign stat.sel_last     = sel_last;

  // Memory port selection
  always_comb begin
    a_we = (ctl.op == OP_LINK1);
    a_re = (ctl.op == OP_SCAN_RD) || (ctl.op == OP_SEL_RD);
    a_ra = (ctl.op == OP_SCAN_RD) ? idx_r : cur_r[SLOT_W-1:0];
    p_re = (ctl.op == OP_UNL_RD) || (ctl.op == OP_SEL_RD);
    p_ra = (ctl.op == OP_UNL_RD) ? s_r[SLOT_W-1:0] : cur_r[SLOT_W-1:0];
    n_re = (ctl.op == OP_UNL_RD);
    f_re = (ctl.op == OP_POP_RD);
    f_ra = SLOT_W'(fc_r - 7'd1);
    f_we = (ctl.op == OP_UNL3) && (fc_r < MAX_RESULTS);
    f_wa = fc_r[SLOT_W-1:0];
    p_we = 1'b0;
    p_wa = s_r[SLOT_W-1:0];
    p_wd = NO_SLOT;
    n_we = 1'b0;
    n_wa = s_r[SLOT_W-1:0];
    n_wd = NO_SLOT;
    case (ctl.op)
      OP_LINK1: begin
        p_we = (mr_r < NO_SLOT);
        p_wa = mr_r[SLOT_W-1:0];
        p_wd = s_r;
        n_we = 1'b1;
        n_wd = mr_r;
      end
      OP_LINK2: begin
        p_we = 1'b1;
      end
      OP_UNL2: begin
        p_we = (next_q < NO_SLOT);
        p_wa = next_q[SLOT_W-1:0];
        p_wd = prev_q;
        n_we = (prev_q < NO_SLOT);
        n_wa = prev_q[SLOT_W-1:0];
        n_wd = next_q;
      end
      OP_UNL3: begin
        p_we = 1'b1;
        n_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Address memory
  always_ff @(posedge clk) begin
    if (a_we) addr_mem[s_r[SLOT_W-1:0]] <= addr_r;
    if (a_re) addr_q <= addr_mem[a_ra];
  end

  // Link toward more recent
  always_ff @(posedge clk) begin
    if (p_we) prev_mem[p_wa] <= p_wd;
    if (p_re) prev_q <= prev_mem[p_ra];
  end

  // Link toward less recent
  always_ff @(posedge clk) begin
    if (n_we) next_mem[n_wa] <= n_wd;
    if (n_re) next_q <= next_mem[s_r[SLOT_W-1:0]];
  end

  // Free stack
  always_ff @(posedge clk) begin
    if (f_we) free_mem[f_wa] <= s_r[SLOT_W-1:0];
    if (f_re) free_q <= free_mem[f_ra];
  end

  // Control state: valid bits, counters, list ends, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fc_r        <= '0;
      nu_r        <= '0;
      mr_r        <= NO_SLOT;
      lr_r        <= NO_SLOT;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (ctl.op)
        OP_POP_RD:   fc_r <= fc_r - 7'd1;
        OP_NEW_TAKE: nu_r <= nu_r + 7'd1;
        OP_LINK1:    valid_r[s_r[SLOT_W-1:0]] <= 1'b1;
        OP_LINK2: begin
          mr_r <= s_r;
          if (lr_r >= NO_SLOT) lr_r <= s_r;
        end
        OP_UNL2: begin
          if (prev_q >= NO_SLOT) mr_r <= next_q;
          if (next_q >= NO_SLOT) lr_r <= prev_q;
        end
        OP_UNL3: begin
          valid_r[s_r[SLOT_W-1:0]] <= 1'b0;
          if (fc_r < MAX_RESULTS) fc_r <= fc_r + 7'd1;
        end
        OP_EMIT, OP_SEL_EMIT: out_valid_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_r  <= in_cmd;
        addr_r <= in_addr;
        lim_r  <= (in_max > MAX_RESULTS) ? MAX_RESULTS : in_max;
        idx_r  <= '0;
        s_r    <= NO_SLOT;
      end
      OP_SCAN_CMP: begin
        if (match) s_r <= {1'b0, idx_r};
        idx_r <= idx_r + 6'd1;
      end
      OP_POP_TAKE: s_r <= {1'b0, free_q};
      OP_NEW_TAKE: s_r <= nu_r;
      OP_SEL_INIT: begin
        cur_r <= lr_r;
        n_r   <= '0;
      end
      OP_EMIT: begin
        out_status       <= ctl.res.status;
        out_slot         <= ctl.res.slot_ok ? s_r : NO_SLOT;
        out_offset       <= ctl.res.slot_ok ? (64'(s_r) << PAGE_SHIFT) : '1;
        out_resident     <= ctl.res.resident;
        out_victim       <= '0;
        out_victim_valid <= 1'b0;
        out_last         <= 1'b1;
      end
      OP_SEL_EMIT: begin
        out_status       <= ST_OK;
        out_slot         <= NO_SLOT;
        out_offset       <= '1;
        out_resident     <= 1'b0;
        out_victim       <= addr_q;
        out_victim_valid <= 1'b1;
        out_last         <= sel_last;
        cur_r            <= prev_q;
        n_r              <= n_r + 7'd1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/ptlru_ctrl.sv =====
// Controller: sequences search, allocation, link updates and select walks.
`timescale 1ns / 1ps
module ptlru_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_cmd,
  input  ptlru_pkg::dp_stat_t stat,
  output ptlru_pkg::ctl_t     ctl
);
  import ptlru_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_SRD   = 17'h00002,
    S_SCMP  = 17'h00004,
    S_DISP  = 17'h00008,
    S_POPRD = 17'h00010,
    S_POPTK = 17'h00020,
    S_NEWTK = 17'h00040,
    S_L1    = 17'h00080,
    S_L2    = 17'h00100,
    S_URD   = 17'h00200,
    S_U2    = 17'h00400,
    S_U3    = 17'h00800,
    S_SINIT = 17'h01000,
    S_SCHK  = 17'h02000,
    S_SELRD = 17'h04000,
    S_SELEM = 17'h08000,
    S_EMIT  = 17'h10000
  } state_t;

  localparam res_t RES_NF    = '{status: ST_NOT_FOUND, slot_ok: 1'b0, resident: 1'b0};
  localparam res_t RES_HIT   = '{status: ST_OK, slot_ok: 1'b1, resident: 1'b1};

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;

  // State and pending result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RES_NF;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    ctl.op    = OP_NONE;
    ctl.res   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op = OP_LOAD;
          if (in_cmd == CMD_SELECT) begin
            state_nxt = S_SINIT;
          end else if (in_cmd > CMD_SELECT) begin
            res_nxt   = RES_NF;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        ctl.op    = OP_SCAN_RD;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        ctl.op    = OP_SCAN_CMP;
        state_nxt = (stat.match || stat.scan_last) ? S_DISP : S_SRD;
      end
      S_DISP: begin
        state_nxt = S_EMIT;
        res_nxt   = RES_NF;
        case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.hit) begin
              res_nxt = '{status: ST_RESIDENT, slot_ok: 1'b0, resident: 1'b1};
            end else if (stat.free_avail) begin
              state_nxt = S_POPRD;
            end else if (stat.unused_avail) begin
              state_nxt = S_NEWTK;
            end else begin
              res_nxt = '{status: ST_FULL, slot_ok: 1'b0, resident: 1'b0};
            end
          end
          CMD_FREE: begin
            if (stat.hit) state_nxt = S_URD;
          end
          CMD_TOUCH: begin
            if (stat.hit && stat.is_mr) res_nxt = RES_HIT;
            else if (stat.hit) state_nxt = S_URD;
          end
          CMD_LOOKUP: begin
            if (stat.hit) res_nxt = RES_HIT;
          end
          default: begin
          end
        endcase
      end
      S_POPRD: begin
        ctl.op    = OP_POP_RD;
        state_nxt = S_POPTK;
      end
      S_POPTK: begin
        ctl.op    = OP_POP_TAKE;
        state_nxt = S_L1;
      end
      S_NEWTK: begin
        ctl.op    = OP_NEW_TAKE;
        state_nxt = S_L1;
      end
      S_L1: begin
        ctl.op    = OP_LINK1;
        state_nxt = S_L2;
      end
      S_L2: begin
        ctl.op    = OP_LINK2;
        res_nxt   = RES_HIT;
        state_nxt = S_EMIT;
      end
      S_URD: begin
        ctl.op    = OP_UNL_RD;
        state_nxt = S_U2;
      end
      S_U2: begin
        ctl.op    = OP_UNL2;
        state_nxt = (stat.cmd == CMD_TOUCH) ? S_L1 : S_U3;
      end
      S_U3: begin
        ctl.op    = OP_UNL3;
        res_nxt   = '{status: ST_OK, slot_ok: 1'b1, resident: 1'b0};
        state_nxt = S_EMIT;
      end
      S_SINIT: begin
        ctl.op    = OP_SEL_INIT;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (stat.sel_more) begin
          state_nxt = S_SELRD;
        end else begin
          res_nxt   = '{status: ST_OK, slot_ok: 1'b0, resident: 1'b0};
          state_nxt = S_EMIT;
        end
      end
      S_SELRD: begin
        ctl.op    = OP_SEL_RD;
        state_nxt = S_SELEM;
      end
      S_SELEM: begin
        if (!stat.out_busy) begin
          ctl.op    = OP_SEL_EMIT;
          state_nxt = stat.sel_last ? S_IDLE : S_SELRD;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          ctl.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/page_table_with_lru_order_top.sv =====
// Top level: page table with recency ordered slots, stream command and result channels.
`timescale 1ns / 1ps
// Maps 64-bit logical page addresses onto 64 physical slots and keeps the resident
// slots in a recency list. One command at a time: the address search reads and then
// compares one slot of the address memory at a time, up to the match or the last slot;
// allocate, free and touch then go on to the free-stack and link updates. Select needs
// no search: after setup it reads and emits one address at a time, least recent first,
// and waits while the output register is still full. The next command is accepted while
// the final result still waits on the output register. No clearing pass follows reset;
// the block is ready at once.
module page_table_with_lru_order_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // logical_addr[63:0], max_count[70:64], zero pad
  input  logic [2:0]   in_tuser,   // cmd[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // status[1:0], slot_index[8:2], byte_offset[72:9],
                                   // resident[73], victim_addr[137:74], zero pad
  output logic [0:0]   out_tuser,  // victim_valid[0]
  output logic         out_tlast
);
  import ptlru_pkg::*;

  ctl_t       ctl;
  dp_stat_t   stat;
  logic [1:0] o_status;
  logic [6:0] o_slot;
  logic [63:0] o_offset, o_victim;
  logic       o_resident, o_vvalid, o_last;

  ptlru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .stat     (stat),
    .ctl      (ctl)
  );

  ptlru_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_cmd           (in_tuser),
    .in_addr          (in_tdata[63:0]),
    .in_max           (in_tdata[70:64]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_status       (o_status),
    .out_slot         (o_slot),
    .out_offset       (o_offset),
    .out_resident     (o_resident),
    .out_victim       (o_victim),
    .out_victim_valid (o_vvalid),
    .out_last         (o_last)
  );

  // Result packing
  assign out_tdata = {6'd0, o_victim, o_resident, o_offset, o_slot, o_status};
  assign out_tuser = o_vvalid;
  assign out_tlast = o_last;

`ifndef SYNTHESIS
  // A new result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_EMIT || ctl.op == OP_SEL_EMIT) |-> !out_tvalid)
    else $error("result register overwritten");

  // The block is not ready again in the cycle after it takes a command
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command accepted while busy");

  // A select transaction without the last mark is followed by more of the walk
  a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_SEL_EMIT && !stat.sel_last) |=> ctl.op == OP_SEL_RD)
    else $error("select walk stopped early");
`endif

endmodule
